@@ src/lwbc_pkg.sv @@
// Shared types, codes and helpers for the LRU write-back block cache.
// Used by every module of the cache; depends on nothing else.
`default_nettype none

package lwbc_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int CNT_W         = 6;
    localparam int SLOT_OUT_W    = 5;
    localparam int BLK_W         = 32;
    localparam int STAT_W        = 32;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_FAIL  = 3'd2,
        OP_SYNC  = 3'd3,
        OP_DROP  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        K_RD_HIT   = 3'd0,
        K_RD_MISS  = 3'd1,
        K_WR_HIT   = 3'd2,
        K_WR_MISS  = 3'd3,
        K_WRBACK   = 3'd4,
        K_FLUSH    = 3'd5,
        K_REJECT   = 3'd6,
        K_DONE     = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        CL_READ,
        CL_WRITE,
        CL_FAIL,
        CL_SYNC,
        CL_DROP,
        CL_REJECT
    } t_cls;

    typedef struct packed {
        t_cls                  cls;
        logic [BLK_W-1:0]      blk;
        logic [SLOT_OUT_W-1:0] fs;
    } t_cmd;

    // Result item without the last mark, most significant field first.
    typedef struct packed {
        logic [STAT_W-1:0]     wb_cnt;
        logic [STAT_W-1:0]     devict_cnt;
        logic [STAT_W-1:0]     evict_cnt;
        logic [STAT_W-1:0]     miss_cnt;
        logic [STAT_W-1:0]     hit_cnt;
        logic [CNT_W-1:0]      dirty;
        logic [CNT_W-1:0]      resident;
        logic [BLK_W-1:0]      blk;
        logic [SLOT_OUT_W-1:0] slot;
        t_kind                 kind;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_APPLY,
        ST_WB,
        ST_SCAN,
        ST_FIN
    } t_state;

    function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] a);
        logic [STAT_W-1:0] r;
        r = (a == '1) ? a : a + 1'b1;
        return r;
    endfunction

    function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + {{(STAT_W+1-CNT_W){1'b0}}, b};
        return s[STAT_W] ? '1 : s[STAT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/lwbc_front.sv @@
// Front end: holds the device size register and classifies each input item.
// Depends on lwbc_pkg.
`default_nettype none

module lwbc_front
    import lwbc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [BLK_W-1:0]      i_cfg_wdata,
    input  wire logic [2:0]            i_opcode,
    input  wire logic [BLK_W-1:0]      i_blk,
    input  wire logic [SLOT_OUT_W-1:0] i_fs,
    output t_cmd                       o_cmd
);

    logic [BLK_W-1:0] r_dev_blocks;

    // Device block count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_blocks <= '0;
        end else if (i_cfg_we) begin
            r_dev_blocks <= i_cfg_wdata;
        end
    end

    // Classify the item; out-of-range accesses and unknown opcodes are rejected.
    always_comb begin
        o_cmd.blk = i_blk;
        o_cmd.fs  = i_fs;
        case (i_opcode)
            OP_READ:  o_cmd.cls = (i_blk < r_dev_blocks) ? CL_READ : CL_REJECT;
            OP_WRITE: o_cmd.cls = (i_blk < r_dev_blocks) ? CL_WRITE : CL_REJECT;
            OP_FAIL:  o_cmd.cls = CL_FAIL;
            OP_SYNC:  o_cmd.cls = CL_SYNC;
            OP_DROP:  o_cmd.cls = CL_DROP;
            default:  o_cmd.cls = CL_REJECT;
        endcase
    end

endmodule

`default_nettype wire

@@ src/lwbc_queue.sv @@
// Short command queue between the classifier and the cache engine.
// Depends on lwbc_pkg.
`default_nettype none

module lwbc_queue
    import lwbc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && o_valid) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push && !o_full) - (PW+1)'(i_pop && o_valid);
        end
    end

endmodule

`default_nettype wire

@@ src/lwbc_back.sv @@
// Cache engine: slot tags, valid/dirty marks, LRU ranks, statistics and the
// result register. Depends on lwbc_pkg.
`default_nettype none

module lwbc_back
    import lwbc_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_cmd i_q_cmd,
    output logic      o_q_pop,
    output logic      o_valid,
    output logic      o_last,
    output t_result   o_res,
    input  wire logic i_ready
);

    localparam int SW = $clog2(NUM_SLOTS);

    t_state r_state;
    t_state n_state;

    t_cmd              r_cmd;
    logic [BLK_W-1:0]  r_block [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_valid;
    logic [NUM_SLOTS-1:0] r_dirty;
    logic [SW-1:0]     r_rank [NUM_SLOTS];
    logic [CNT_W-1:0]  r_res_cnt;
    logic [CNT_W-1:0]  r_dty_cnt;
    logic [STAT_W-1:0] r_hits, r_misses, r_evicts, r_devicts, r_wbs;

    logic              r_hit;
    logic [SW-1:0]     r_hit_idx;
    logic [SW-1:0]     r_vict;
    logic [SW-1:0]     r_ptr;
    logic              r_wb_pend;
    logic [SW-1:0]     r_wb_slot;
    logic [BLK_W-1:0]  r_wb_blk;
    t_kind             r_fin_kind;
    logic [SLOT_OUT_W-1:0] r_fin_slot;
    logic [BLK_W-1:0]  r_fin_blk;

    logic              out_free;
    logic              emit_wb, emit_fin, scan_emit, scan_adv;
    logic              scan_vd;
    logic              hit_c;
    logic [SW-1:0]     hit_idx_c, vict_c;
    logic [SW-1:0]     rd_idx;
    logic [BLK_W-1:0]  rd_blk;
    logic [SW-1:0]     mru_idx;
    logic [SW-1:0]     fs_idx;
    logic              fs_ok;
    logic              is_wr;
    logic              v_valid, v_dirty;

    function automatic logic [SLOT_OUT_W-1:0] to_slot(input logic [SW-1:0] idx);
        logic [SW+SLOT_OUT_W-1:0] e;
        e = {{SLOT_OUT_W{1'b0}}, idx};
        return e[SLOT_OUT_W-1:0];
    endfunction

    assign out_free = !o_valid || i_ready;

    // Associative match and rank-zero victim search.
    always_comb begin
        hit_c     = 1'b0;
        hit_idx_c = '0;
        vict_c    = '0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (r_valid[j] && r_block[j] == r_cmd.blk) begin
                hit_c     = 1'b1;
                hit_idx_c = SW'(j);
            end
            if (r_rank[j] == '0) begin
                vict_c = SW'(j);
            end
        end
    end

    // Shared tag read port and per-item helpers.
    always_comb begin
        logic [SW+SLOT_OUT_W-1:0] fe;
        fe       = {{SW{1'b0}}, r_cmd.fs};
        fs_idx   = fe[SW-1:0];
        fs_ok    = {2'b00, r_cmd.fs} < 7'(NUM_SLOTS);
        rd_idx   = (r_state == ST_SCAN) ? r_ptr : r_vict;
        rd_blk   = r_block[rd_idx];
        mru_idx  = r_hit ? r_hit_idx : r_vict;
        is_wr    = (r_cmd.cls == CL_WRITE);
        v_valid  = r_valid[r_vict];
        v_dirty  = r_dirty[r_vict];
        scan_vd  = r_valid[r_ptr] && r_dirty[r_ptr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_cmd.cls == CL_READ || i_q_cmd.cls == CL_WRITE)
                              ? ST_LOOK : ST_APPLY;
                end
            end
            ST_LOOK:  n_state = ST_APPLY;
            ST_APPLY: begin
                if (r_cmd.cls == CL_SYNC) begin
                    n_state = ST_SCAN;
                end else if ((r_cmd.cls == CL_READ || r_cmd.cls == CL_WRITE) &&
                             !r_hit && v_valid && v_dirty) begin
                    n_state = ST_WB;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_WB:   if (out_free) n_state = ST_FIN;
            ST_SCAN: if (scan_adv && r_ptr == SW'(NUM_SLOTS-1)) n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_q_pop   = 1'b0;
        emit_wb   = 1'b0;
        emit_fin  = 1'b0;
        scan_emit = 1'b0;
        scan_adv  = 1'b0;
        case (r_state)
            ST_IDLE: o_q_pop  = i_q_valid;
            ST_WB:   emit_wb  = out_free && r_wb_pend;
            ST_FIN:  emit_fin = out_free;
            ST_SCAN: begin
                scan_emit = scan_vd && out_free;
                scan_adv  = !scan_vd || out_free;
            end
            default: o_q_pop = 1'b0;
        endcase
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_wb || emit_fin || scan_emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Result register; counts already hold the values after the step.
    always_ff @(posedge i_clk) begin
        if (emit_wb || emit_fin || scan_emit) begin
            o_last            <= emit_fin;
            o_res.hit_cnt     <= r_hits;
            o_res.miss_cnt    <= r_misses;
            o_res.evict_cnt   <= r_evicts;
            o_res.devict_cnt  <= r_devicts;
            o_res.wb_cnt      <= r_wbs;
            o_res.resident    <= r_res_cnt;
            o_res.dirty       <= r_dty_cnt;
            if (emit_fin) begin
                o_res.kind <= r_fin_kind;
                o_res.slot <= r_fin_slot;
                o_res.blk  <= r_fin_blk;
            end else if (emit_wb) begin
                o_res.kind <= K_WRBACK;
                o_res.slot <= to_slot(r_wb_slot);
                o_res.blk  <= r_wb_blk;
            end else begin
                o_res.kind <= K_WRBACK;
                o_res.slot <= to_slot(r_ptr);
                o_res.blk  <= rd_blk;
            end
        end
    end

    // Item latch, lookup registers and per-item payload.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == ST_LOOK) begin
            r_hit     <= hit_c;
            r_hit_idx <= hit_idx_c;
            r_vict    <= vict_c;
        end
        if (r_state == ST_APPLY) begin
            r_wb_pend <= (r_cmd.cls == CL_READ || r_cmd.cls == CL_WRITE) &&
                         !r_hit && v_valid && v_dirty;
            r_wb_slot <= r_vict;
            r_wb_blk  <= rd_blk;
            case (r_cmd.cls)
                CL_READ, CL_WRITE: begin
                    r_fin_blk <= r_cmd.blk;
                    if (r_hit) begin
                        r_fin_kind <= is_wr ? K_WR_HIT : K_RD_HIT;
                        r_fin_slot <= to_slot(r_hit_idx);
                    end else begin
                        r_fin_kind <= is_wr ? K_WR_MISS : K_RD_MISS;
                        r_fin_slot <= to_slot(r_vict);
                    end
                end
                CL_FAIL: begin
                    r_fin_kind <= K_DONE;
                    r_fin_slot <= r_cmd.fs;
                    r_fin_blk  <= '0;
                end
                CL_SYNC: begin
                    r_fin_kind <= K_FLUSH;
                    r_fin_slot <= '0;
                    r_fin_blk  <= '0;
                end
                CL_DROP: begin
                    r_fin_kind <= K_DONE;
                    r_fin_slot <= '0;
                    r_fin_blk  <= '0;
                end
                default: begin
                    r_fin_kind <= K_REJECT;
                    r_fin_slot <= '0;
                    r_fin_blk  <= r_cmd.blk;
                end
            endcase
        end
        if (o_q_pop) begin
            r_ptr <= '0;
        end else if (scan_adv) begin
            r_ptr <= r_ptr + 1'b1;
        end
    end

    // Tag store: written only when a miss claims its victim.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_APPLY && (r_cmd.cls == CL_READ || r_cmd.cls == CL_WRITE) &&
            !r_hit) begin
            r_block[r_vict] <= r_cmd.blk;
        end
    end

    // Slot marks, ranks, occupancy counts and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_dirty   <= '0;
            for (int j = 0; j < NUM_SLOTS; j++) begin
                r_rank[j] <= SW'(j);
            end
            r_res_cnt <= '0;
            r_dty_cnt <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_evicts  <= '0;
            r_devicts <= '0;
            r_wbs     <= '0;
        end else begin
            if (scan_emit) begin
                r_dirty[r_ptr] <= 1'b0;
            end
            if (r_state == ST_APPLY) begin
                case (r_cmd.cls)
                    CL_READ, CL_WRITE: begin
                        // Move the served or claimed slot to most recent.
                        for (int j = 0; j < NUM_SLOTS; j++) begin
                            if (r_rank[j] > r_rank[mru_idx]) begin
                                r_rank[j] <= r_rank[j] - 1'b1;
                            end
                        end
                        r_rank[mru_idx] <= SW'(NUM_SLOTS-1);
                        if (r_hit) begin
                            r_hits <= sat_inc(r_hits);
                            if (is_wr) begin
                                r_dirty[r_hit_idx] <= 1'b1;
                                if (!r_dirty[r_hit_idx]) begin
                                    r_dty_cnt <= r_dty_cnt + 1'b1;
                                end
                            end
                        end else begin
                            r_misses        <= sat_inc(r_misses);
                            r_valid[r_vict] <= 1'b1;
                            r_dirty[r_vict] <= is_wr;
                            r_dty_cnt <= r_dty_cnt - CNT_W'(v_valid && v_dirty)
                                         + CNT_W'(is_wr);
                            if (!v_valid) begin
                                r_res_cnt <= r_res_cnt + 1'b1;
                            end else begin
                                r_evicts <= sat_inc(r_evicts);
                                if (v_dirty) begin
                                    r_wbs     <= sat_inc(r_wbs);
                                    r_devicts <= sat_inc(r_devicts);
                                end
                            end
                        end
                    end
                    CL_FAIL: begin
                        if (fs_ok) begin
                            // Released slot becomes least recent.
                            for (int j = 0; j < NUM_SLOTS; j++) begin
                                if (r_rank[j] < r_rank[fs_idx]) begin
                                    r_rank[j] <= r_rank[j] + 1'b1;
                                end
                            end
                            r_rank[fs_idx]  <= '0;
                            r_valid[fs_idx] <= 1'b0;
                            r_dirty[fs_idx] <= 1'b0;
                            r_res_cnt <= r_res_cnt - CNT_W'(r_valid[fs_idx]);
                            r_dty_cnt <= r_dty_cnt -
                                         CNT_W'(r_valid[fs_idx] && r_dirty[fs_idx]);
                        end
                    end
                    CL_SYNC: begin
                        // Every dirty slot is written back during the scan.
                        r_wbs     <= sat_add(r_wbs, r_dty_cnt);
                        r_dty_cnt <= '0;
                    end
                    CL_DROP: begin
                        r_valid   <= '0;
                        r_dirty   <= '0;
                        r_res_cnt <= '0;
                        r_dty_cnt <= '0;
                        for (int j = 0; j < NUM_SLOTS; j++) begin
                            r_rank[j] <= SW'(NUM_SLOTS-1-j);
                        end
                    end
                    default: r_res_cnt <= r_res_cnt;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ src/lru_writeback_block_cache.sv @@
// Top level of the LRU write-back block cache tag engine.
// Depends on lwbc_pkg, lwbc_front, lwbc_queue and lwbc_back.
//
// Usage: requests enter on the s-side stream (opcode, block number, failed
// slot) and results leave on the m-side stream, one or more per request,
// with tlast on the final result of each request. The device block count
// is written through i_cfg_we/i_cfg_wdata while the cache is idle.
// A read or write passes through the queue, the tag match, the update
// and the result register to its final result, with a write-back
// result first when a dirty victim is evicted. Fetch failure, drop and
// rejects skip the tag match. Sync walks the slots one a cycle unless a
// stalled receiver holds a write-back result back. The engine handles one
// request at a time; the two-entry queue keeps taking requests meanwhile.
// Reset: all slots invalid and clean, slot s at LRU rank s, statistics
// and the device block count zero, so every access is rejected until the
// count is written.
// A stalled receiver holds the result register and the engine waits; the
// queue fills and then deasserts o_s_tready.
`default_nettype none

module lru_writeback_block_cache
    import lwbc_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // opcode[2:0], block_number[34:3], failed_slot[39:35]
    input  wire logic [39:0]  i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // kind[2:0], slot[7:3], block_out[39:8], resident_count[45:40],
    // dirty_count[51:46], hit_count[83:52], miss_count[115:84],
    // eviction_count[147:116], dirty_eviction_count[179:148],
    // writeback_count[211:180], zero fill above
    output logic [215:0]      o_m_tdata,
    output logic              o_m_tlast
);

    t_cmd    front_cmd;
    t_cmd    q_cmd;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    t_result res;

    assign o_s_tready = !q_full;

    lwbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_opcode    (i_s_tdata[2:0]),
        .i_blk       (i_s_tdata[34:3]),
        .i_fs        (i_s_tdata[39:35]),
        .o_cmd       (front_cmd)
    );

    lwbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    lwbc_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .o_last    (o_m_tlast),
        .o_res     (res),
        .i_ready   (i_m_tready)
    );

    // Pack the result item, kind in the lowest bits.
    assign o_m_tdata = {4'b0000, res};

endmodule

`default_nettype wire

@@ tb/sv/tb_lru_writeback_block_cache.sv @@
// Testbench for the LRU write-back block cache tag engine.
// Depends on lwbc_pkg and lru_writeback_block_cache; predicts every result in place.
`default_nettype none

module tb_lru_writeback_block_cache;
    import lwbc_pkg::*;

    localparam int NSLOT = 32;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  slot;
        logic [31:0] blk;
        logic        last;
        logic [5:0]  resident;
        logic [5:0]  dirty;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evicts;
        logic [31:0] devicts;
        logic [31:0] wbacks;
    } t_expect;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [31:0]  i_cfg_wdata;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [39:0]  i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [215:0] o_m_tdata;
    logic         o_m_tlast;

    lru_writeback_block_cache i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    // Predictor state.
    logic [31:0] cache_blk [NSLOT];
    logic        cache_vld [NSLOT];
    logic        cache_dty [NSLOT];
    int          cache_rank[NSLOT];
    logic [31:0] n_hit, n_miss, n_evict, n_devict, n_wb;
    logic [31:0] block_limit;

    logic [39:0] pending_items[$];
    t_expect     expected_results[$];
    t_expect     step_out[$];
    int          error_count = 0;
    bit          quiet_mode = 0;
    bit          hold_off = 0;
    int          sent_count = 0;
    bit          in_taken = 0;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == '1) ? v : v + 1;
    endfunction

    function automatic void touch_mru(int s);
        int r;
        r = cache_rank[s];
        for (int j = 0; j < NSLOT; j++) if (cache_rank[j] > r) cache_rank[j]--;
        cache_rank[s] = NSLOT - 1;
    endfunction

    function automatic void push_result(logic [2:0] k, logic [4:0] s, logic [31:0] b);
        t_expect e;
        e = '0;
        e.kind = k; e.slot = s; e.blk = b;
        step_out.push_back(e);
    endfunction

    // Works out the results of one request and appends them to the expected list.
    function automatic void predict_request(logic [39:0] item);
        logic [2:0]  op;
        logic [31:0] b;
        logic [4:0]  fs;
        int s, v, r, nres, ndty;
        t_expect e;
        op = item[2:0]; b = item[34:3]; fs = item[39:35];
        step_out.delete();
        if (op == OP_READ || op == OP_WRITE) begin
            if (b >= block_limit) begin
                push_result(K_REJECT, 0, b);
            end else begin
                s = -1;
                for (int j = 0; j < NSLOT; j++)
                    if (s < 0 && cache_vld[j] && cache_blk[j] == b) s = j;
                if (s >= 0) begin
                    n_hit = bump(n_hit);
                    if (op == OP_WRITE) cache_dty[s] = 1;
                    touch_mru(s);
                    push_result(op == OP_READ ? K_RD_HIT : K_WR_HIT, 5'(s), b);
                end else begin
                    n_miss = bump(n_miss);
                    v = 0;
                    for (int j = NSLOT - 1; j >= 0; j--) if (cache_rank[j] == 0) v = j;
                    if (cache_vld[v]) begin
                        if (cache_dty[v]) begin
                            push_result(K_WRBACK, 5'(v), cache_blk[v]);
                            n_wb = bump(n_wb);
                            n_devict = bump(n_devict);
                        end
                        n_evict = bump(n_evict);
                    end
                    cache_blk[v] = b; cache_vld[v] = 1; cache_dty[v] = (op == OP_WRITE);
                    touch_mru(v);
                    push_result(op == OP_READ ? K_RD_MISS : K_WR_MISS, 5'(v), b);
                end
            end
        end else if (op == OP_FAIL) begin
            s = fs;
            cache_vld[s] = 0; cache_dty[s] = 0;
            r = cache_rank[s];
            for (int j = 0; j < NSLOT; j++) if (cache_rank[j] < r) cache_rank[j]++;
            cache_rank[s] = 0;
            push_result(K_DONE, fs, 0);
        end else if (op == OP_SYNC) begin
            for (int j = 0; j < NSLOT; j++)
                if (cache_vld[j] && cache_dty[j]) begin
                    push_result(K_WRBACK, 5'(j), cache_blk[j]);
                    cache_dty[j] = 0;
                    n_wb = bump(n_wb);
                end
            push_result(K_FLUSH, 0, 0);
        end else if (op == OP_DROP) begin
            for (int j = 0; j < NSLOT; j++) begin
                cache_vld[j] = 0; cache_dty[j] = 0; cache_rank[j] = NSLOT - 1 - j;
            end
            push_result(K_DONE, 0, 0);
        end else begin
            push_result(K_REJECT, 0, b);
        end
        nres = 0; ndty = 0;
        for (int j = 0; j < NSLOT; j++) if (cache_vld[j]) begin
            nres++;
            if (cache_dty[j]) ndty++;
        end
        foreach (step_out[k]) begin
            e = step_out[k];
            e.last = (k == step_out.size() - 1);
            e.resident = 6'(nres); e.dirty = 6'(ndty);
            e.hits = n_hit; e.misses = n_miss; e.evicts = n_evict;
            e.devicts = n_devict; e.wbacks = n_wb;
            expected_results.push_back(e);
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // Records each input handshake at the edge where it happens.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_s_tvalid && o_s_tready;
    end

    // Driver: offers queued items, with random idle bursts.
    int idle_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (in_taken) begin
                predict_request(i_s_tdata);
                void'(pending_items.pop_front());
                sent_count++;
            end
            if (i_s_tvalid && !in_taken) begin
                i_s_tvalid <= 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0 && !quiet_mode
                         && $urandom_range(0, 9) == 0) begin
                idle_left = $urandom_range(1, 14) - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_items[0];
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready with random stalls and an optional long hold-off.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result kind", o_m_tdata[2:0], 0);
            end else begin
                e = expected_results.pop_front();
                if (o_m_tdata[2:0] != e.kind) report_mismatch("kind", o_m_tdata[2:0], e.kind);
                if (o_m_tdata[7:3] != e.slot) report_mismatch("slot", o_m_tdata[7:3], e.slot);
                if (o_m_tdata[39:8] != e.blk) report_mismatch("block", o_m_tdata[39:8], e.blk);
                if (o_m_tlast != e.last) report_mismatch("last", o_m_tlast, e.last);
                if (o_m_tdata[45:40] != e.resident)
                    report_mismatch("resident", o_m_tdata[45:40], e.resident);
                if (o_m_tdata[51:46] != e.dirty)
                    report_mismatch("dirty", o_m_tdata[51:46], e.dirty);
                if (o_m_tdata[83:52] != e.hits) report_mismatch("hits", o_m_tdata[83:52], e.hits);
                if (o_m_tdata[115:84] != e.misses)
                    report_mismatch("misses", o_m_tdata[115:84], e.misses);
                if (o_m_tdata[147:116] != e.evicts)
                    report_mismatch("evictions", o_m_tdata[147:116], e.evicts);
                if (o_m_tdata[179:148] != e.devicts)
                    report_mismatch("dirty evictions", o_m_tdata[179:148], e.devicts);
                if (o_m_tdata[211:180] != e.wbacks)
                    report_mismatch("writebacks", o_m_tdata[211:180], e.wbacks);
                if (o_m_tdata[215:212] != 0) report_mismatch("fill", o_m_tdata[215:212], 0);
            end
        end
    end

    function automatic logic [39:0] make_item(logic [2:0] op, logic [31:0] b, logic [4:0] fs);
        return {fs, b, op};
    endfunction

    // Waits until everything sent has been checked, then lets the engine settle.
    task automatic drain();
        wait (pending_items.size() == 0 && !i_s_tvalid);
        wait (expected_results.size() == 0);
        repeat (NSLOT + 8) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        block_limit = v;
    endtask

    // A random request; mostly accesses within a small working set.
    task automatic queue_random(logic [31:0] span);
        int pick;
        logic [31:0] b;
        pick = $urandom_range(0, 99);
        b = (span == 0) ? $urandom : $urandom_range(0, span - 1);
        if ($urandom_range(0, 19) == 0) b = $urandom;
        if (pick < 45)      pending_items.push_back(make_item(OP_READ, b, $urandom));
        else if (pick < 88) pending_items.push_back(make_item(OP_WRITE, b, $urandom));
        else if (pick < 93) pending_items.push_back(make_item(OP_FAIL, $urandom, $urandom));
        else if (pick < 96) pending_items.push_back(make_item(OP_SYNC, $urandom, $urandom));
        else if (pick < 98) pending_items.push_back(make_item(OP_DROP, $urandom, $urandom));
        else pending_items.push_back(make_item($urandom_range(5, 7), $urandom, $urandom));
    endtask

    initial begin
        for (int j = 0; j < NSLOT; j++) begin
            cache_blk[j] = 0; cache_vld[j] = 0; cache_dty[j] = 0; cache_rank[j] = j;
        end
        n_hit = 0; n_miss = 0; n_evict = 0; n_devict = 0; n_wb = 0; block_limit = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        i_s_tvalid = 1'b0; i_s_tdata = '0; i_m_tready = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: everything rejected with the reset limit of zero.
        pending_items.push_back(make_item(OP_READ, 0, 0));
        pending_items.push_back(make_item(OP_WRITE, 32'hFFFF_FFFF, 5'h1F));
        drain();
        write_limit(32'hFFFF_FFFF);
        pending_items.push_back(make_item(OP_WRITE, 32'hFFFF_FFFE, 0));
        pending_items.push_back(make_item(OP_READ, 32'hFFFF_FFFE, 0));
        pending_items.push_back(make_item(OP_READ, 32'hFFFF_FFFF, 0));
        pending_items.push_back(make_item(OP_READ, 0, 0));
        pending_items.push_back(make_item(OP_WRITE, 0, 0));
        pending_items.push_back(make_item(OP_FAIL, 0, 5'h1F));
        pending_items.push_back(make_item(OP_FAIL, 0, 0));
        pending_items.push_back(make_item(OP_SYNC, 0, 0));
        pending_items.push_back(make_item(OP_WRITE, 7, 0));
        pending_items.push_back(make_item(OP_SYNC, 0, 0));
        pending_items.push_back(make_item(3'd5, 32'h1234_5678, 0));
        pending_items.push_back(make_item(3'd7, 32'hFFFF_FFFF, 5'h1F));
        pending_items.push_back(make_item(OP_DROP, 0, 0));
        pending_items.push_back(make_item(OP_READ, 7, 0));
        // Fill every slot dirty, then evict dirty victims and sync all.
        for (int j = 0; j < 34; j++) pending_items.push_back(make_item(OP_WRITE, 100 + j, 0));
        pending_items.push_back(make_item(OP_SYNC, 0, 0));
        drain();

        // Random phases with small limits; the receiver holds off in the first.
        write_limit(48);
        for (int j = 0; j < 110; j++) queue_random(48);
        hold_off = 1;
        repeat (200) @(posedge i_clk);
        hold_off = 0;
        drain();
        write_limit(1);
        for (int j = 0; j < 20; j++) queue_random(2);
        drain();
        write_limit(40);
        for (int j = 0; j < 110; j++) queue_random(40);
        drain();
        // Last part without idle bursts or receiver stalls.
        quiet_mode = 1;
        write_limit(32'hFFFF_FFFF);
        for (int j = 0; j < 60; j++) queue_random(36);
        drain();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
